### src/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

	localparam int BW      = 19;
	localparam int CFG_MAX = 131071;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;

	typedef struct packed {
		logic        free;
		logic [16:0] bytes;
	} entry_t;

endpackage

### src/ffha_mem.sv
// Block table memory: one write port, one registered read port.
module ffha_mem #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  ffha_pkg::entry_t         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output ffha_pkg::entry_t         rdata
);
	import ffha_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### src/ffha_seq.sv
// Sequencer: table walk, split, growth, coalesce and result register.
module ffha_seq #(
	parameter int MAX_BLOCKS      = 64,
	parameter int HEADER_BYTES    = 24,
	parameter int MIN_SPLIT_BYTES = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              op,
	input  logic [15:0]             address,
	input  logic [16:0]             size,
	input  logic [ffha_pkg::BW-1:0] limit,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [15:0]             result_address,
	output logic [15:0]             move_from,
	output logic [16:0]             move_bytes
);
	import ffha_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	localparam logic [BW-1:0] HB   = BW'(HEADER_BYTES);
	localparam logic [BW-1:0] MS   = BW'(MIN_SPLIT_BYTES);
	localparam logic [BW-1:0] AMAX = BW'(16'hFFFF);

	typedef enum logic [4:0] {
		S_IDLE, S_L_ISSUE, S_L_CHK, S_G_ISSUE, S_G_CHK, S_SU_ISSUE, S_SU_WR,
		S_SPLIT1, S_SPLIT2, S_G_USE, S_G_GROW, S_R_MARK, S_R_ISSUE, S_R_CHK,
		S_SD_ISSUE, S_SD_WR, S_FIN
	} state_t;

	state_t        state_q;
	logic [1:0]    op_q;
	logic [15:0]   addr_q;
	logic [16:0]   size_q;
	logic [CW-1:0] total_q, i_q, j_q;
	logic [BW-1:0] top_q, start_q;
	logic [16:0]   cur_q, old_q;
	logic          phase2_q;
	logic [1:0]    st_q;
	logic [15:0]   res_q, from_q;
	logic [16:0]   mvb_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [15:0]   result_q, move_from_q;
	logic [16:0]   move_bytes_q;

	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, rd;

	logic [CW-1:0] ip1, jp1, jm1;
	logic [BW-1:0] rb, sz, ua, step, need, tua, merged;
	logic          gdone;

	assign ip1    = i_q + CW'(1);
	assign jp1    = j_q + CW'(1);
	assign jm1    = j_q - CW'(1);
	assign rb     = BW'(rd.bytes);
	assign sz     = BW'(size_q);
	assign ua     = start_q + HB;
	assign step   = ua + rb;
	assign tua    = top_q + HB;
	assign need   = tua + sz;
	assign merged = BW'(cur_q) + HB + rb;

	ffha_mem #(.DEPTH(MAX_BLOCKS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q[IW-1:0];
		mem_wdata = '{free: 1'b0, bytes: size_q};
		mem_raddr = i_q[IW-1:0];
		gdone     = 1'b0;
		case (state_q)
			S_SU_ISSUE: mem_raddr = jm1[IW-1:0];
			S_SU_WR: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[IW-1:0];
				mem_wdata = rd;
			end
			S_SPLIT1: begin
				mem_we    = 1'b1;
				mem_waddr = ip1[IW-1:0];
				mem_wdata = '{free: 1'b1, bytes: 17'(BW'(cur_q) - sz - HB)};
			end
			S_SPLIT2: begin
				mem_we = 1'b1;
				gdone  = 1'b1;
			end
			S_G_USE: begin
				mem_we    = 1'b1;
				mem_wdata = '{free: 1'b0, bytes: cur_q};
				gdone     = 1'b1;
			end
			S_G_GROW: begin
				mem_waddr = total_q[IW-1:0];
				if (!(total_q >= MAXC || need > limit || tua > AMAX)) begin
					mem_we = 1'b1;
					gdone  = 1'b1;
				end
			end
			S_R_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = '{free: 1'b1, bytes: cur_q};
			end
			S_R_ISSUE: mem_raddr = ip1[IW-1:0];
			S_R_CHK: begin
				mem_we    = rd.free;
				mem_wdata = '{free: 1'b1, bytes: merged[16:0]};
			end
			S_SD_ISSUE: mem_raddr = jp1[IW-1:0];
			S_SD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[IW-1:0];
				mem_wdata = rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			addr_q      <= '0;
			size_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			start_q     <= '0;
			cur_q       <= '0;
			old_q       <= '0;
			phase2_q    <= 1'b0;
			st_q        <= ST_OK;
			res_q       <= '0;
			from_q      <= '0;
			mvb_q       <= '0;
			status_q    <= ST_OK;
			result_q    <= '0;
			move_from_q <= '0;
			move_bytes_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= op;
						addr_q   <= address;
						size_q   <= size;
						st_q     <= ST_OK;
						res_q    <= '0;
						from_q   <= '0;
						mvb_q    <= '0;
						phase2_q <= 1'b0;
						i_q      <= '0;
						start_q  <= '0;
						case (op)
							OP_ALLOC:   state_q <= S_G_ISSUE;
							OP_FREE:    state_q <= (address == 16'd0) ? S_FIN : S_L_ISSUE;
							OP_REALLOC: state_q <= (address == 16'd0) ? S_G_ISSUE : S_L_ISSUE;
							default:    state_q <= S_FIN;
						endcase
					end
				end
				S_L_ISSUE: begin
					if (i_q >= total_q) begin
						st_q    <= ST_BADADDR;
						state_q <= S_FIN;
					end else begin
						state_q <= S_L_CHK;
					end
				end
				S_L_CHK: begin
					if (ua == BW'(addr_q)) begin
						cur_q <= rd.bytes;
						if (op_q == OP_FREE || phase2_q) begin
							state_q <= S_R_MARK;
						end else if (rb >= sz) begin
							res_q   <= addr_q;
							state_q <= S_FIN;
						end else begin
							old_q   <= rd.bytes;
							i_q     <= '0;
							start_q <= '0;
							state_q <= S_G_ISSUE;
						end
					end else begin
						start_q <= step;
						i_q     <= ip1;
						state_q <= S_L_ISSUE;
					end
				end
				S_G_ISSUE: state_q <= (i_q >= total_q) ? S_G_GROW : S_G_CHK;
				S_G_CHK: begin
					if (rd.free && rb >= sz && ua <= AMAX) begin
						res_q <= ua[15:0];
						cur_q <= rd.bytes;
						if (rb >= sz + HB + MS && total_q < MAXC) begin
							j_q     <= total_q;
							state_q <= S_SU_ISSUE;
						end else begin
							state_q <= S_G_USE;
						end
					end else begin
						start_q <= step;
						i_q     <= ip1;
						state_q <= S_G_ISSUE;
					end
				end
				S_SU_ISSUE: state_q <= (j_q > ip1) ? S_SU_WR : S_SPLIT1;
				S_SU_WR: begin
					j_q     <= jm1;
					state_q <= S_SU_ISSUE;
				end
				S_SPLIT1: state_q <= S_SPLIT2;
				S_SPLIT2: total_q <= total_q + CW'(1);
				S_G_USE: ;
				S_G_GROW: begin
					if (gdone) begin
						total_q <= total_q + CW'(1);
						top_q   <= need;
						res_q   <= tua[15:0];
					end else begin
						st_q    <= ST_NOSPACE;
						res_q   <= '0;
						state_q <= S_FIN;
					end
				end
				S_R_MARK: state_q <= S_R_ISSUE;
				S_R_ISSUE: state_q <= (ip1 < total_q) ? S_R_CHK : S_FIN;
				S_R_CHK: begin
					if (rd.free) begin
						cur_q   <= merged[16:0];
						j_q     <= ip1;
						state_q <= S_SD_ISSUE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SD_ISSUE: begin
					if (jp1 < total_q) begin
						state_q <= S_SD_WR;
					end else begin
						total_q <= total_q - CW'(1);
						state_q <= S_R_ISSUE;
					end
				end
				S_SD_WR: begin
					j_q     <= jp1;
					state_q <= S_SD_ISSUE;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						status_q     <= st_q;
						result_q     <= res_q;
						move_from_q  <= from_q;
						move_bytes_q <= mvb_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (gdone) begin
				if (op_q == OP_REALLOC && addr_q != 16'd0) begin
					from_q   <= addr_q;
					mvb_q    <= old_q;
					phase2_q <= 1'b1;
					i_q      <= '0;
					start_q  <= '0;
					state_q  <= S_L_ISSUE;
				end else begin
					state_q <= S_FIN;
				end
			end
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = result_q;
	assign move_from      = move_from_q;
	assign move_bytes     = move_bytes_q;
endmodule

### src/first_fit_heap_allocator.sv
// First-fit heap allocator: configuration register and sequencer.
// One request at a time: a request walks the block table block by block (memory
// read, then check), a split shifts later entries up and each merge of a coalesce
// shifts them down. A free of null or an unknown op goes straight to its result
// without touching the table; a reallocate that moves walks the table three
// times (lookup, search, lookup again), grants, splits and coalesces, and every
// merged neighbor shifts the rest of the table. in_stall stays high while a
// request is in work; a finished result waits in the output register. No
// clearing pass runs after reset.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES      = 65536,
	parameter int MAX_BLOCKS      = 64,
	parameter int HEADER_BYTES    = 24,
	parameter int MIN_SPLIT_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] address,
	input  logic [16:0] size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] result_address,
	output logic [15:0] move_from,
	output logic [16:0] move_bytes
);
	import ffha_pkg::*;

	localparam int HCAP = (HEAP_BYTES > CFG_MAX) ? CFG_MAX : HEAP_BYTES;
	localparam logic [BW-1:0] HCAP_B = BW'(HCAP);

	logic [16:0]   heap_limit_q;
	logic [BW-1:0] limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= 17'd65536;
		end else if (cfg_valid) begin
			heap_limit_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign limit = (BW'(heap_limit_q) < HCAP_B) ? BW'(heap_limit_q) : HCAP_B;

	ffha_seq #(
		.MAX_BLOCKS      (MAX_BLOCKS),
		.HEADER_BYTES    (HEADER_BYTES),
		.MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.address        (address),
		.size           (size),
		.limit          (limit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.result_address (result_address),
		.move_from      (move_from),
		.move_bytes     (move_bytes)
	);
endmodule

### src/ffha_chk.sv
// Port-level checks of the first-fit heap allocator, bound to the top level.
module ffha_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] result_address,
	input logic [15:0] move_from,
	input logic [16:0] move_bytes
);
	import ffha_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken without going busy");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BADADDR |-> result_address == 16'd0 && move_bytes == 17'd0)
		else $error("bad address result carries data");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_from != 16'd0 |-> status == ST_OK && result_address != 16'd0)
		else $error("move reported without a grant");
endmodule

bind first_fit_heap_allocator ffha_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.result_address (result_address),
	.move_from      (move_from),
	.move_bytes     (move_bytes)
);
